// File: rtl/stable_priority_queue_assert.svh
// assertion macros used by the priority queue top level
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH
`ifndef SYNTH
`define SPQ_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("priority queue assertion failed");
`define SPQ_ASSERT_IMPLY(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("priority queue assertion failed");
`define SPQ_ASSERT_NEXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("priority queue assertion failed");
`else
`define SPQ_ASSERT(lbl, prop)
`define SPQ_ASSERT_IMPLY(lbl, cond, prop)
`define SPQ_ASSERT_NEXT(lbl, cond, prop)
`endif
`endif

// File: rtl/spq_pkg.sv
// types, codes and defaults of the priority queue
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;
	localparam int DEPTH_DEFAULT = 16;
	localparam int ID_W = 31;
	localparam int PRIO_W = 16;

	localparam logic [1:0] OP_INSERT  = 2'd0;
	localparam logic [1:0] OP_EXTRACT = 2'd1;
	localparam logic [1:0] OP_DISCARD = 2'd2;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [ID_W-1:0]   new_id;
		logic [PRIO_W-1:0] new_priority;
	} cmd_word_t;

	typedef struct packed {
		logic [1:0]        status;
		logic              head_valid;
		logic [ID_W-1:0]   head_id;
		logic [PRIO_W-1:0] head_priority;
	} result_word_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic   ins;
		logic   pop;
		entry_t new_ent;
	} cell_ctl_t;
endpackage
`default_nettype wire

// File: rtl/spq_cell.sv
// one slot of the sorted chain: holds an entry and shifts with its neighbors
`timescale 1ns / 1ps
`default_nettype none
module spq_cell
	import spq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cell_ctl_t ctl,
	input  wire logic      occ,
	input  wire logic      left_keep,
	input  wire entry_t    left_ent,
	input  wire entry_t    right_ent,
	output logic           keep,
	output entry_t         ent
);
	entry_t ent_q;

	// stays put on insert: stored entry is served no later than the new one
	assign keep = occ && (ent_q.prio <= ctl.new_ent.prio);
	assign ent  = ent_q;

	// slot cleared at reset, only occupied slots are ever served
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (ctl.ins) begin
			if (!keep) begin
				ent_q <= left_keep ? ctl.new_ent : left_ent;
			end
		end else if (ctl.pop) begin
			ent_q <= right_ent;
		end
	end
endmodule
`default_nettype wire

// File: rtl/stable_priority_queue.sv
// top level of the stable sorted priority queue
// usage:
//   command channel: drive cmd and raise start; the word is taken at a
//   rising edge with start high and busy low. busy stays low, so a new
//   command may be issued in every cycle.
//   result channel: one result word per command, shown on result for exactly
//   one cycle with done high, in the cycle after the command is taken.
//   throughput is one command per cycle; the whole sorted shift of the
//   chain of cells is set by one 16-bit compare per cell plus a neighbor
//   select.
//   insert: every cell compares its priority with the new one; cells with
//   equal or smaller priority value keep their entry, the first other cell takes the
//   new word and the rest shift one place toward the tail.
//   extract/discard: all cells shift one place toward the head.
//   status reports empty on extract/discard of an empty queue and full on
//   insert into a full queue (the word is dropped).
//   reset empties the queue (entry count to zero) and clears done.
//   the receiver cannot stall: a result not taken in its cycle is lost.
`timescale 1ns / 1ps
`default_nettype none
`include "stable_priority_queue_assert.svh"
module stable_priority_queue
	import spq_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEPTH_DEFAULT
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	input  wire cmd_word_t    cmd,
	output logic              done,
	output result_word_t      result
);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	logic [CNT_W-1:0] count_q;
	logic             done_q;
	result_word_t     result_q;

	logic      accept;
	logic      full;
	logic      empty;
	cell_ctl_t ctl;
	result_word_t res_d;

	entry_t cell_ent [QUEUE_DEPTH];
	logic   cell_keep [QUEUE_DEPTH];

	// chain updated directly on each command, always ready
	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == CNT_FULL);
	assign empty  = (count_q == '0);

	assign ctl.ins     = accept && (cmd.opcode == OP_INSERT) && !full;
	assign ctl.pop     = accept && ((cmd.opcode == OP_EXTRACT) || (cmd.opcode == OP_DISCARD))
		&& !empty;
	assign ctl.new_ent = '{id: cmd.new_id, prio: cmd.new_priority};

	// the chain: cell 0 is the head
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic   occ;
		logic   lkeep;
		entry_t lent;
		entry_t rent;

		assign occ = (CNT_W'(i) < count_q);
		if (i == 0) begin : g_head
			assign lkeep = 1'b1;
			assign lent  = ctl.new_ent;
		end else begin : g_body
			assign lkeep = cell_keep[i-1];
			assign lent  = cell_ent[i-1];
		end
		// tail cell refills with itself; the count drop leaves it unoccupied
		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign rent = cell_ent[i];
		end else begin : g_mid
			assign rent = cell_ent[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.occ       (occ),
			.left_keep (lkeep),
			.left_ent  (lent),
			.right_ent (rent),
			.keep      (cell_keep[i]),
			.ent       (cell_ent[i])
		);
	end

	// result word of the command being taken
	always_comb begin
		res_d = '0;
		unique case (cmd.opcode)
			OP_INSERT: begin
				if (full) begin
					res_d.status = ST_FULL;
				end
			end
			OP_EXTRACT: begin
				if (empty) begin
					res_d.status = ST_EMPTY;
				end else begin
					res_d.head_valid    = 1'b1;
					res_d.head_id       = cell_ent[0].id;
					res_d.head_priority = cell_ent[0].prio;
				end
			end
			OP_DISCARD: begin
				if (empty) begin
					res_d.status = ST_EMPTY;
				end
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (ctl.ins) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// result payload, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`SPQ_ASSERT(a_count_bound, count_q <= CNT_FULL)
	`SPQ_ASSERT_NEXT(a_done_follows, accept, done)
	`SPQ_ASSERT_NEXT(a_no_spurious_done, !accept, !done)
	`SPQ_ASSERT_IMPLY(a_head_ok, done && result.head_valid, result.status == ST_DONE)
	`SPQ_ASSERT_IMPLY(a_head_sorted, count_q >= CNT_W'(2), cell_ent[0].prio <= cell_ent[1].prio)
	`SPQ_ASSERT_NEXT(a_insert_grows, ctl.ins, count_q == $past(count_q) + 1'b1)
endmodule
`default_nettype wire
